// File: design/tevq_pkg.sv
// Package: shared action codes, sequencer states and constants of the timed event queue.
`timescale 1ns / 1ps
package tevq_pkg;

   localparam int MAX_RESULTS = 16;
   localparam int TIME_W      = 64;
   localparam int COUNT_W     = 5;

   typedef enum logic [2:0] {
      ACT_TICK   = 3'd0,
      ACT_ADD    = 3'd1,
      ACT_CANCEL = 3'd2,
      ACT_RUN    = 3'd3,
      ACT_SET    = 3'd4,
      ACT_CLEAR  = 3'd5
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD_RD,
      ST_ADD_WT,
      ST_CAN_RD,
      ST_CAN_WT,
      ST_RUN_RD,
      ST_RUN_WT,
      ST_FIRE_RD,
      ST_FIRE_WT,
      ST_FIRE_OUT,
      ST_CMP_RD,
      ST_CMP_WT,
      ST_RESP
   } state_type;

endpackage

// File: design/timed_event_queue_core.sv
// Top level: action sequencer and status registers around the sorted event store.
// Add shifts later-or-equal entries up and inserts; cancel compacts out entries with the id;
// run reads due entries from the head, returns one result per due event (at most MAX_RESULTS)
// and then moves the remaining entries down. Tick, set, clear and a full-store add respond
// directly. A new request is taken only in idle, once the previous one has completed.
// Reset clears time, count and the sequencer; store contents stay as they were.
`timescale 1ns / 1ps
module timed_event_queue_core #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [71:0]  req_tdata,  // amount[63:0], event_id[71:64]
   input  logic [2:0]   req_tuser,  // action[2:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // fired_id[7:0], fired_time[71:8], now_time[135:72], queue_empty[136],
   // next_time[200:137], count[205:201], status[206], zero[207]
   output logic [207:0] rsp_tdata,
   output logic [0:0]   rsp_tuser,  // fired[0]
   output logic         rsp_tlast
);
   import tevq_pkg::*;

   localparam int IW = (ID_BITS < 8) ? ID_BITS : 8;
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int DW = TIME_W + IW;

   state_type state_ff, state_in;

   logic [TIME_W-1:0] now_ff, head_ff, new_time_ff;
   logic [CW-1:0]     count_ff, rd_ptr_ff, wr_ptr_ff, k_ff;
   logic [IW-1:0]     id_ff;
   logic              drop_ff;
   logic              fired_ff, last_ff;
   logic [IW-1:0]     fired_id_ff;
   logic [TIME_W-1:0] fired_time_ff;

   logic              mem_wr_en, mem_rd_en;
   logic [AW-1:0]     mem_wr_addr, mem_rd_addr;
   logic [DW-1:0]     mem_wr_data, mem_rd_data;
   logic [TIME_W-1:0] rd_time;
   logic [IW-1:0]     rd_id;

   action_type        req_action;
   logic [TIME_W-1:0] req_amount;
   logic [IW-1:0]     req_id;
   logic              req_fire, rsp_fire;
   logic              run_due;
   logic [CW-1:0]     cmp_src;

   assign req_action = action_type'(req_tuser);
   assign req_amount = req_tdata[63:0];
   assign req_id     = req_tdata[64 +: IW];
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign rd_time    = mem_rd_data[DW-1 -: TIME_W];
   assign rd_id      = mem_rd_data[IW-1:0];
   assign run_due    = (32'(rd_ptr_ff) < MAX_RESULTS) && (rd_time <= now_ff);
   assign cmp_src    = rd_ptr_ff + k_ff;

   tevq_ram #(.DEPTH(QUEUE_DEPTH), .AW(AW), .DW(DW)) u_ram (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_action)
                  ACT_ADD:    state_in = (32'(count_ff) >= QUEUE_DEPTH) ? ST_RESP : ST_ADD_RD;
                  ACT_CANCEL: state_in = ST_CAN_RD;
                  ACT_RUN:    state_in = ST_RUN_RD;
                  default:    state_in = ST_RESP;
               endcase
            end
         end
         ST_ADD_RD:  state_in = (rd_ptr_ff == '0) ? ST_RESP : ST_ADD_WT;
         ST_ADD_WT:  state_in = (rd_time >= new_time_ff) ? ST_ADD_RD : ST_RESP;
         ST_CAN_RD:  state_in = (rd_ptr_ff == count_ff) ? ST_RESP : ST_CAN_WT;
         ST_CAN_WT:  state_in = ST_CAN_RD;
         ST_RUN_RD: begin
            if (rd_ptr_ff == count_ff) begin
               state_in = (rd_ptr_ff == '0) ? ST_RESP : ST_FIRE_RD;
            end else begin
               state_in = ST_RUN_WT;
            end
         end
         ST_RUN_WT: begin
            if (run_due) begin
               state_in = ST_RUN_RD;
            end else begin
               state_in = (rd_ptr_ff == '0) ? ST_RESP : ST_FIRE_RD;
            end
         end
         ST_FIRE_RD: state_in = ST_FIRE_WT;
         ST_FIRE_WT: state_in = ST_FIRE_OUT;
         ST_FIRE_OUT: begin
            if (rsp_fire) begin
               state_in = last_ff ? ST_CMP_RD : ST_FIRE_RD;
            end
         end
         ST_CMP_RD:  state_in = (rd_ptr_ff == count_ff) ? ST_IDLE : ST_CMP_WT;
         ST_CMP_WT:  state_in = ST_CMP_RD;
         ST_RESP:    state_in = rsp_fire ? ST_IDLE : ST_RESP;
         default:    state_in = ST_IDLE;
      endcase
   end

   // memory control
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = {new_time_ff, id_ff};
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;
      case (state_ff)
         ST_ADD_RD: begin
            if (rd_ptr_ff == '0) begin
               mem_wr_en = 1'b1;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(rd_ptr_ff - 1'b1);
            end
         end
         ST_ADD_WT: begin
            // shift later-or-equal entries up, else drop the new event in
            mem_wr_en   = 1'b1;
            mem_wr_addr = AW'(rd_ptr_ff);
            if (rd_time >= new_time_ff) begin
               mem_wr_data = mem_rd_data;
            end
         end
         ST_CAN_RD, ST_RUN_RD, ST_FIRE_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = AW'(rd_ptr_ff);
         end
         ST_CAN_WT: begin
            mem_wr_en   = (rd_id != id_ff);
            mem_wr_addr = AW'(wr_ptr_ff);
            mem_wr_data = mem_rd_data;
         end
         ST_CMP_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = AW'(cmp_src);
         end
         ST_CMP_WT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = AW'(rd_ptr_ff);
            mem_wr_data = mem_rd_data;
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         now_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  case (req_action)
                     ACT_TICK:  now_ff   <= now_ff + req_amount;
                     ACT_SET:   now_ff   <= req_amount;
                     ACT_CLEAR: count_ff <= '0;
                     default:   now_ff   <= now_ff;
                  endcase
               end
            end
            ST_ADD_RD:  if (rd_ptr_ff == '0) count_ff <= count_ff + 1'b1;
            ST_ADD_WT:  if (rd_time < new_time_ff) count_ff <= count_ff + 1'b1;
            ST_CAN_RD:  if (rd_ptr_ff == count_ff) count_ff <= wr_ptr_ff;
            ST_RUN_RD:  if (rd_ptr_ff == count_ff) count_ff <= '0;
            ST_RUN_WT:  if (!run_due) count_ff <= count_ff - rd_ptr_ff;
            default:    count_ff <= count_ff;
         endcase
      end
   end

   // datapath and pointers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            new_time_ff <= now_ff + req_amount;
            id_ff       <= req_id;
            drop_ff     <= (req_action == ACT_ADD) && (32'(count_ff) >= QUEUE_DEPTH);
            fired_ff    <= 1'b0;
            last_ff     <= 1'b1;
            fired_id_ff <= '0;
            fired_time_ff <= '0;
            wr_ptr_ff   <= '0;
            rd_ptr_ff   <= (req_action == ACT_ADD) ? count_ff : '0;
         end
         ST_ADD_RD: begin
            if (rd_ptr_ff == '0) head_ff <= new_time_ff;
         end
         ST_ADD_WT: begin
            if (rd_time >= new_time_ff) rd_ptr_ff <= rd_ptr_ff - 1'b1;
         end
         ST_CAN_WT: begin
            if (rd_id != id_ff) begin
               if (wr_ptr_ff == '0) head_ff <= rd_time;
               wr_ptr_ff <= wr_ptr_ff + 1'b1;
            end
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         ST_RUN_RD: begin
            if (rd_ptr_ff == count_ff) begin
               k_ff      <= rd_ptr_ff;
               rd_ptr_ff <= '0;
            end
         end
         ST_RUN_WT: begin
            if (run_due) begin
               rd_ptr_ff <= rd_ptr_ff + 1'b1;
            end else begin
               k_ff      <= rd_ptr_ff;
               head_ff   <= rd_time;
               rd_ptr_ff <= '0;
            end
         end
         ST_FIRE_WT: begin
            fired_ff      <= 1'b1;
            fired_id_ff   <= rd_id;
            fired_time_ff <= rd_time;
            last_ff       <= (rd_ptr_ff + 1'b1 == k_ff);
         end
         ST_FIRE_OUT: begin
            if (rsp_fire) rd_ptr_ff <= last_ff ? '0 : rd_ptr_ff + 1'b1;
         end
         ST_CMP_WT: begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         default: begin
            id_ff <= id_ff;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_RESP) || (state_ff == ST_FIRE_OUT);
      rsp_tlast  = last_ff;
      rsp_tuser  = fired_ff;
      rsp_tdata  = {1'b0,
                    drop_ff,
                    COUNT_W'(count_ff),
                    (count_ff == '0) ? {TIME_W{1'b0}} : head_ff,
                    (count_ff == '0),
                    now_ff,
                    fired_time_ff,
                    8'(fired_id_ff)};
   end

endmodule

// File: design/tevq_ram.sv
// Event store: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module tevq_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int DW    = 72
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
